/* rtl/core/thermostat_mode_controller_defines.svh */
// Assertion macros shared by the thermostat mode controller RTL.
`ifndef THERMOSTAT_MODE_CONTROLLER_DEFINES_SVH
`define THERMOSTAT_MODE_CONTROLLER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define TMC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tmc_pkg.sv */
// Package: constants, types and helper functions of the thermostat mode controller.
package tmc_pkg;

    localparam int NUM_SAMPLES     = 10;
    localparam int SCHEDULE_PERIOD = 20;
    localparam int SAMPLE_W        = 8;
    localparam int TICK_W          = 5;
    localparam int SUM_W           = $clog2(NUM_SAMPLES * 255 + 1);
    // covers sum + band*N and (setpoint + band)*N
    localparam int CMP_W           = $clog2(NUM_SAMPLES * (255 + 31 + 128) + 1);

    localparam logic [2:0] SAMPLE_TICK_MASK = 3'b111;

    localparam logic [6:0] INIT_SETPOINT = 7'd60;
    localparam logic [6:0] LOWER_RST     = 7'd35;
    localparam logic [6:0] UPPER_RST     = 7'd75;
    localparam logic [4:0] STEP_RST      = 5'd5;
    localparam logic [4:0] BAND_RST      = 5'd5;
    localparam logic [3:0] TIMEOUT_RST   = 4'd10;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_SETTING = 2'd1,
        MODE_RUNNING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ELEM_HEAT = 2'd0,
        ELEM_COOL = 2'd1,
        ELEM_NONE = 2'd2
    } elem_t;

    typedef enum logic [2:0] {
        CFG_LOWER_LIMIT = 3'd0,
        CFG_UPPER_LIMIT = 3'd1,
        CFG_STEP        = 3'd2,
        CFG_BAND        = 3'd3,
        CFG_TIMEOUT     = 3'd4,
        CFG_DEADBAND    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [6:0] lower_limit;
        logic [6:0] upper_limit;
        logic [4:0] step;
        logic [4:0] band;
        logic [3:0] timeout;
        logic       deadband_off;
    } cfg_t;

    typedef struct packed {
        logic power;
        logic up;
        logic down;
    } buttons_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    // Decimal digits of a value below 512: divide by 10 through reciprocal multiply.
    function automatic digits_t to_digits(logic [8:0] v);
        logic [17:0] p1;
        logic [6:0]  q;
        logic [11:0] p2;
        logic [3:0]  q2;
        digits_t     d;
        p1     = 18'(v) * 18'd205;
        q      = p1[17:11];
        p2     = 12'(q) * 12'd26;
        q2     = p2[11:8];
        d.tens = 4'(q - 7'(q2) * 7'd10);
        d.ones = 4'(v - 9'(q) * 9'd10);
        return d;
    endfunction

endpackage

/* rtl/core/tmc_if.sv */
// Channel interfaces: tick input and result output with valid/ready.
interface tmc_in_if;
    logic       valid;
    logic       ready;
    logic       power_button;
    logic       up_button;
    logic       down_button;
    logic [9:0] sensor_sample;

    modport source (output valid, power_button, up_button, down_button, sensor_sample,
                    input ready);
    modport sink   (input valid, power_button, up_button, down_button, sensor_sample,
                    output ready);
endinterface

interface tmc_out_if;
    logic       valid;
    logic       ready;
    logic       heater_on;
    logic       cooler_on;
    logic       indicator_led;
    logic       display_enable;
    logic [3:0] display_tens;
    logic [3:0] display_ones;
    logic [1:0] operating_mode;
    logic [6:0] setpoint_value;

    modport source (output valid, heater_on, cooler_on, indicator_led, display_enable,
                    display_tens, display_ones, operating_mode, setpoint_value,
                    input ready);
    modport sink   (input valid, heater_on, cooler_on, indicator_led, display_enable,
                    display_tens, display_ones, operating_mode, setpoint_value,
                    output ready);
endinterface

/* rtl/core/tmc_sample_cell.sv */
// One cell of the sample chain: holds one halved sample, passes it on when shifted.
module tmc_sample_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [tmc_pkg::SAMPLE_W-1:0] d,
    output logic [tmc_pkg::SAMPLE_W-1:0] q
);

    logic [tmc_pkg::SAMPLE_W-1:0] q_reg;
    logic [tmc_pkg::SAMPLE_W-1:0] q_next;

    assign q_next = shift_en ? d : q_reg;
    assign q      = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

endmodule

/* rtl/core/tmc_sample_chain.sv */
// Row of sample cells with a running sum; the tail cell holds the oldest sample.
module tmc_sample_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [tmc_pkg::SAMPLE_W-1:0] sample_in,
    output logic [tmc_pkg::SUM_W-1:0]    sum_shifted
);

    logic [tmc_pkg::SAMPLE_W-1:0] tap [0:tmc_pkg::NUM_SAMPLES];
    logic [tmc_pkg::SUM_W-1:0]    sum_reg;
    logic [tmc_pkg::SUM_W-1:0]    sum_next;

    assign tap[0] = sample_in;

    for (genvar i = 0; i < tmc_pkg::NUM_SAMPLES; i++)
    begin : g_cell
        tmc_sample_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d        (tap[i]),
            .q        (tap[i+1])
        );
    end

    // sum after the new sample enters and the oldest drops out
    assign sum_shifted = sum_reg + tmc_pkg::SUM_W'(sample_in)
                       - tmc_pkg::SUM_W'(tap[tmc_pkg::NUM_SAMPLES]);
    assign sum_next    = shift_en ? sum_shifted : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

/* rtl/core/thermostat_mode_controller.sv */
// A tick's result is on out_ch in the cycle after its transfer (registered state).
// Throughput: one tick per cycle; the mode/setpoint update and the sample chain's
// running sum both complete in the cycle of the transfer.
// A result waiting on a stalled sink holds new ticks back only until it is taken.
// Reset (rst_n, async, active low): power-up mode, setpoints, limits and drives;
// sample chain cleared at once, no clearing pass.
`include "thermostat_mode_controller_defines.svh"

module thermostat_mode_controller (
    input  logic           clk,
    input  logic           rst_n,
    tmc_in_if.sink         in_ch,
    tmc_out_if.source      out_ch,
    input  logic           cfg_write,
    input  logic [2:0]     cfg_index,
    input  logic [6:0]     cfg_data
);

    typedef struct packed {
        tmc_pkg::mode_t mode;
        logic [6:0]     setpoint;
        logic [3:0]     count;
    } step_t;

    // Up/down release: running enters setting; in setting the setpoint steps with clamping.
    function automatic step_t step_setpoint(step_t s, logic up, tmc_pkg::cfg_t cfg);
        step_t      r;
        logic [7:0] sum;
        logic [6:0] stp;
        r   = s;
        stp = {2'b00, cfg.step};
        sum = 8'(s.setpoint) + 8'(stp);
        unique case (s.mode)
            tmc_pkg::MODE_RUNNING:
            begin
                r.mode  = tmc_pkg::MODE_SETTING;
                r.count = '0;
            end
            tmc_pkg::MODE_SETTING:
            begin
                if (up)
                begin
                    r.setpoint = (sum > 8'(cfg.upper_limit)) ? cfg.upper_limit : sum[6:0];
                end
                else if (s.setpoint < stp || (s.setpoint - stp) < cfg.lower_limit)
                begin
                    r.setpoint = cfg.lower_limit;
                end
                else
                begin
                    r.setpoint = s.setpoint - stp;
                end
                r.count = '0;
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    tmc_pkg::cfg_t     cfg_reg;
    tmc_pkg::mode_t    mode_reg, mode_next;
    tmc_pkg::elem_t    elem_reg, elem_next;
    tmc_pkg::buttons_t prev_reg, prev_next;
    logic [6:0]        setpoint_reg, setpoint_next;
    logic [6:0]        saved_reg, saved_next;
    logic [3:0]        count_reg, count_next;
    logic [tmc_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic              heater_reg, heater_next;
    logic              cooler_reg, cooler_next;
    logic              led_reg, led_next;
    logic              disp_en_reg, disp_en_next;
    tmc_pkg::digits_t  digits_reg, digits_next;
    logic              led_phase_reg, led_phase_next;
    logic              disp_phase_reg, disp_phase_next;
    logic              out_valid_reg, out_valid_next;

    logic              in_fire;
    logic              sample_tick;
    logic              period_tick;
    logic [8:0]        sample_half;
    logic              shift_en;
    logic [tmc_pkg::SUM_W-1:0] sum_shifted;

    step_t             after_power, after_up, after_down;
    logic              rel_power, rel_up, rel_down;
    logic [tmc_pkg::CMP_W-1:0] sum_ext, hi_lim, band_n, sp_n;

    // output register parts the two sides; a held result blocks only if not taken
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // sampling on counts with low three bits zero; blink/timeout at the period count
    assign sample_tick = (tick_reg[2:0] & tmc_pkg::SAMPLE_TICK_MASK) == 3'b000;
    assign period_tick = tick_reg == tmc_pkg::TICK_W'(tmc_pkg::SCHEDULE_PERIOD);
    assign sample_half = in_ch.sensor_sample[9:1];
    assign shift_en    = in_fire && sample_tick;

    tmc_sample_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (shift_en),
        .sample_in   (sample_half[tmc_pkg::SAMPLE_W-1:0]),
        .sum_shifted (sum_shifted)
    );

    // releases: pressed last tick, not pressed now
    assign rel_power = prev_reg.power && !in_ch.power_button;
    assign rel_up    = prev_reg.up && !in_ch.up_button;
    assign rel_down  = prev_reg.down && !in_ch.down_button;

    // ---------------------------------------------------------------
    // Button handling: power first, then up, then down
    // ---------------------------------------------------------------
    always_comb
    begin
        after_power.mode     = mode_reg;
        after_power.setpoint = setpoint_reg;
        after_power.count    = count_reg;
        if (rel_power)
        begin
            if (mode_reg == tmc_pkg::MODE_OFF)
            begin
                after_power.mode     = tmc_pkg::MODE_RUNNING;
                after_power.setpoint = saved_reg;
            end
            else
            begin
                after_power.mode = tmc_pkg::MODE_OFF;
            end
        end
        after_up   = rel_up ? step_setpoint(after_power, 1'b1, cfg_reg) : after_power;
        after_down = rel_down ? step_setpoint(after_up, 1'b0, cfg_reg) : after_up;
    end

    // control thresholds, scaled by the number of samples to avoid a divide
    assign sum_ext = tmc_pkg::CMP_W'(sum_shifted);
    assign band_n  = tmc_pkg::CMP_W'(cfg_reg.band) * tmc_pkg::CMP_W'(tmc_pkg::NUM_SAMPLES);
    assign sp_n    = tmc_pkg::CMP_W'(after_down.setpoint)
                   * tmc_pkg::CMP_W'(tmc_pkg::NUM_SAMPLES);
    assign hi_lim  = sp_n + band_n;

    // ---------------------------------------------------------------
    // Next state for one tick
    // ---------------------------------------------------------------
    always_comb
    begin
        mode_next       = mode_reg;
        elem_next       = elem_reg;
        prev_next       = prev_reg;
        setpoint_next   = setpoint_reg;
        saved_next      = saved_reg;
        count_next      = count_reg;
        tick_next       = tick_reg;
        heater_next     = heater_reg;
        cooler_next     = cooler_reg;
        led_next        = led_reg;
        disp_en_next    = disp_en_reg;
        digits_next     = digits_reg;
        led_phase_next  = led_phase_reg;
        disp_phase_next = disp_phase_reg;

        if (in_fire)
        begin
            // power off: drives and display dark, setpoint saved
            if (rel_power && mode_reg != tmc_pkg::MODE_OFF)
            begin
                heater_next  = 1'b0;
                cooler_next  = 1'b0;
                led_next     = 1'b0;
                disp_en_next = 1'b0;
                saved_next   = setpoint_reg;
            end
            mode_next     = after_down.mode;
            setpoint_next = after_down.setpoint;
            count_next    = after_down.count;
            if (rel_up || rel_down)
            begin
                digits_next = tmc_pkg::to_digits({2'b00, after_down.setpoint});
            end
            prev_next.power = in_ch.power_button;
            prev_next.up    = in_ch.up_button;
            prev_next.down  = in_ch.down_button;

            if (sample_tick)
            begin
                if (mode_next == tmc_pkg::MODE_RUNNING)
                begin
                    digits_next  = tmc_pkg::to_digits(sample_half);
                    disp_en_next = 1'b1;
                end
                if (mode_next != tmc_pkg::MODE_OFF)
                begin
                    priority if (sum_ext > hi_lim)
                    begin
                        cooler_next = 1'b1;
                        heater_next = 1'b0;
                        led_next    = 1'b1;
                        elem_next   = tmc_pkg::ELEM_COOL;
                    end
                    else if (sum_ext + band_n < sp_n)
                    begin
                        heater_next = 1'b1;
                        cooler_next = 1'b0;
                        elem_next   = tmc_pkg::ELEM_HEAT;
                    end
                    else if (cfg_reg.deadband_off)
                    begin
                        heater_next = 1'b0;
                        cooler_next = 1'b0;
                        led_next    = 1'b0;
                        elem_next   = tmc_pkg::ELEM_NONE;
                    end
                    else
                    begin
                        // inside the band: drives stay as they are
                    end
                end
            end

            if (period_tick)
            begin
                // setting-mode timeout
                if (mode_next == tmc_pkg::MODE_SETTING)
                begin
                    if (count_next == cfg_reg.timeout)
                    begin
                        count_next = '0;
                        mode_next  = tmc_pkg::MODE_RUNNING;
                    end
                    else
                    begin
                        count_next = count_next + 4'd1;
                    end
                end
                // blink LED while heating, display while setting
                if (mode_next != tmc_pkg::MODE_OFF && elem_next == tmc_pkg::ELEM_HEAT)
                begin
                    led_next       = led_phase_reg;
                    led_phase_next = !led_phase_reg;
                end
                if (mode_next == tmc_pkg::MODE_SETTING)
                begin
                    disp_en_next    = disp_phase_reg;
                    disp_phase_next = !disp_phase_reg;
                end
                tick_next = tmc_pkg::TICK_W'(1);
            end
            else
            begin
                tick_next = tick_reg + tmc_pkg::TICK_W'(1);
            end
        end
    end

    // result stays until the sink takes it
    always_comb
    begin
        priority if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tmc_pkg::MODE_OFF;
            elem_reg       <= tmc_pkg::ELEM_NONE;
            prev_reg       <= '0;
            setpoint_reg   <= tmc_pkg::INIT_SETPOINT;
            saved_reg      <= tmc_pkg::INIT_SETPOINT;
            count_reg      <= '0;
            tick_reg       <= '0;
            heater_reg     <= 1'b0;
            cooler_reg     <= 1'b0;
            led_reg        <= 1'b0;
            disp_en_reg    <= 1'b0;
            digits_reg     <= '0;
            led_phase_reg  <= 1'b0;
            disp_phase_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            elem_reg       <= elem_next;
            prev_reg       <= prev_next;
            setpoint_reg   <= setpoint_next;
            saved_reg      <= saved_next;
            count_reg      <= count_next;
            tick_reg       <= tick_next;
            heater_reg     <= heater_next;
            cooler_reg     <= cooler_next;
            led_reg        <= led_next;
            disp_en_reg    <= disp_en_next;
            digits_reg     <= digits_next;
            led_phase_reg  <= led_phase_next;
            disp_phase_reg <= disp_phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers; unknown indexes are ignored
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_limit  <= tmc_pkg::LOWER_RST;
            cfg_reg.upper_limit  <= tmc_pkg::UPPER_RST;
            cfg_reg.step         <= tmc_pkg::STEP_RST;
            cfg_reg.band         <= tmc_pkg::BAND_RST;
            cfg_reg.timeout      <= tmc_pkg::TIMEOUT_RST;
            cfg_reg.deadband_off <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (tmc_pkg::cfg_index_t'(cfg_index))
                tmc_pkg::CFG_LOWER_LIMIT: cfg_reg.lower_limit  <= cfg_data;
                tmc_pkg::CFG_UPPER_LIMIT: cfg_reg.upper_limit  <= cfg_data;
                tmc_pkg::CFG_STEP:        cfg_reg.step         <= cfg_data[4:0];
                tmc_pkg::CFG_BAND:        cfg_reg.band         <= cfg_data[4:0];
                tmc_pkg::CFG_TIMEOUT:     cfg_reg.timeout      <= cfg_data[3:0];
                tmc_pkg::CFG_DEADBAND:    cfg_reg.deadband_off <= cfg_data[0];
                default:                  cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result: the registered state after the last transfer
    // ---------------------------------------------------------------
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.heater_on      = heater_reg;
    assign out_ch.cooler_on      = cooler_reg;
    assign out_ch.indicator_led  = led_reg;
    assign out_ch.display_enable = disp_en_reg;
    assign out_ch.display_tens   = digits_reg.tens;
    assign out_ch.display_ones   = digits_reg.ones;
    assign out_ch.operating_mode = mode_reg;
    assign out_ch.setpoint_value = setpoint_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TMC_ASSERT_ALWAYS(a_drive_excl, !(heater_reg && cooler_reg),
        "heater and cooler driven together")
    `TMC_ASSERT_ALWAYS(a_off_quiet,
        mode_reg != tmc_pkg::MODE_OFF || (!heater_reg && !cooler_reg && !led_reg),
        "drive active while off")
    `TMC_ASSERT_ALWAYS(a_tick_range, tick_reg <= tmc_pkg::TICK_W'(tmc_pkg::SCHEDULE_PERIOD),
        "schedule counter past its period")
    `TMC_ASSERT_NEXT(a_sp_hold, !in_fire, $stable(setpoint_reg) && $stable(mode_reg),
        "setpoint or mode moved without a transfer")

endmodule
